FILE: rtl/core/nts_pkg.sv
// Shared types and constants for the note table sequencer.
// No dependencies; imported by the core, controller, datapath and checker.

package nts_pkg;

   localparam int NREGS       = 3;
   localparam int MAX_VOICES  = 8;
   localparam int VOICE_IDX_W = 3;
   localparam int FREQ_W      = 16;
   localparam int DUR_W       = 8;
   localparam int ENTRY_W     = FREQ_W + DUR_W;

   typedef enum logic [1:0] {
      FUNC_TICK = 2'd0,
      FUNC_PLAY = 2'd1,
      FUNC_STOP = 2'd2,
      FUNC_LOAD = 2'd3
   } func_type;

   localparam logic [1:0] KIND_REST   = 2'd0;
   localparam logic [1:0] KIND_NOTE   = 2'd1;
   localparam logic [1:0] KIND_SILENT = 2'd2;

   localparam logic [1:0] REG_LENGTH_VOICE0 = 2'd0;
   localparam logic [1:0] REG_LENGTH_VOICE1 = 2'd1;
   localparam logic [1:0] REG_LENGTH_VOICE2 = 2'd2;

   typedef struct packed {
      logic                   accept;
      logic                   rd_issue;
      logic                   emit_note;
      logic                   emit_silent;
      logic                   last;
      logic [VOICE_IDX_W-1:0] voice;
      func_type               func;
   } nts_cmd_type;

   typedef struct packed {
      logic                  out_free;
      logic [MAX_VOICES-1:0] trig_mask;
   } nts_status_type;

endpackage

FILE: rtl/core/note_table_sequencer_core.sv
// Top level of the note table sequencer: controller plus datapath.
// Depends on nts_pkg, nts_ctrl, nts_datapath and nts_ram.
//
// Usage:
//   req_* carries one command per transaction: tick, play, stop or load.
//   rsp_* returns trigger results; rsp_last marks the final result of a
//   command. Loads and ticks with no expiring note return nothing.
//   csr_* writes the per-voice table lengths; write only while idle.
// Sequencing: a load completes as it is accepted; a stop goes to the silent
//   state and emits one silent result; tick and play scan the voices in order
//   and emit one result per triggered voice; voices after the last triggered
//   one are skipped. Voices are handled one after another through the
//   single port of the note table RAM, one read per triggered voice.
//   req_stall is high while a command is in progress; the next command is
//   taken as soon as its last result sits in the output register.
// Reset: positions, frame counters and tick counter clear, table lengths
//   return to 1; the note table is not cleared and must be loaded first.
// Stall: a stalled result holds in rsp_*, and the block waits on it before
//   presenting the next result of the same command.

module note_table_sequencer_core #(
   parameter int NOTES_PER_VOICE = 128,
   parameter int VOICE_COUNT     = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [1:0]  req_voice,
   input  logic [6:0]  req_index,
   input  logic [15:0] req_note_freq,
   input  logic [7:0]  req_note_len,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_voice_res,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_freq,
   output logic [7:0]  rsp_tick_count,
   output logic        rsp_last,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import nts_pkg::*;

   nts_cmd_type    cmd;
   nts_status_type status;

   nts_ctrl #(
      .VOICE_COUNT (VOICE_COUNT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_func),
      .status    (status),
      .cmd       (cmd)
   );

   nts_datapath #(
      .NOTES_PER_VOICE (NOTES_PER_VOICE),
      .VOICE_COUNT     (VOICE_COUNT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_func       (req_func),
      .req_voice      (req_voice),
      .req_index      (req_index),
      .req_note_freq  (req_note_freq),
      .req_note_len   (req_note_len),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_voice_res  (rsp_voice_res),
      .rsp_kind       (rsp_kind),
      .rsp_freq       (rsp_freq),
      .rsp_tick_count (rsp_tick_count),
      .rsp_last       (rsp_last)
   );

endmodule

FILE: rtl/core/nts_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.

module nts_ram #(
   parameter int DATA_W = 24,
   parameter int DEPTH  = 384,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic              re,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/core/nts_ctrl.sv
// Sequencer controller: accepts transactions and walks the voices one at a time.
// Depends on nts_pkg; drives nts_datapath through nts_cmd_type.

module nts_ctrl #(
   parameter int VOICE_COUNT = 3
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_func,
   input  nts_pkg::nts_status_type status,
   output nts_pkg::nts_cmd_type    cmd
);
   import nts_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_EMIT,
      S_SILENT
   } state_type;

   localparam logic [VOICE_IDX_W-1:0] LAST_VOICE = VOICE_IDX_W'(VOICE_COUNT - 1);
   localparam logic [MAX_VOICES-1:0]  PLAY_MASK  =
      MAX_VOICES'((32'd1 << VOICE_COUNT) - 32'd1);

   state_type              state_ff, state_in;
   logic [VOICE_IDX_W-1:0] voice_ff, voice_in;
   logic [MAX_VOICES-1:0]  mask_ff, mask_in;
   func_type               func_ff, func_in;
   logic [MAX_VOICES-1:0]  upper_mask;

   assign upper_mask = ~((MAX_VOICES'(2) << voice_ff) - MAX_VOICES'(1));
   assign req_stall  = (state_ff != S_IDLE);

   always_comb begin
      state_in        = state_ff;
      voice_in        = voice_ff;
      mask_in         = mask_ff;
      func_in         = func_ff;
      cmd             = '0;
      cmd.voice       = voice_ff;
      cmd.func        = func_ff;
      cmd.last        = ((mask_ff & upper_mask) == '0);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               func_in    = func_type'(req_func);
               voice_in   = '0;
               case (func_type'(req_func))
                  FUNC_TICK: begin
                     mask_in  = status.trig_mask;
                     state_in = S_SCAN;
                  end
                  FUNC_PLAY: begin
                     mask_in  = PLAY_MASK;
                     state_in = S_SCAN;
                  end
                  FUNC_STOP: begin
                     state_in = S_SILENT;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (mask_ff[voice_ff]) begin
               cmd.rd_issue = 1'b1;
               state_in     = S_EMIT;
            end else if (voice_ff == LAST_VOICE) begin
               state_in = S_IDLE;
            end else begin
               voice_in = voice_ff + 1'b1;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit_note = 1'b1;
               if (cmd.last) begin
                  state_in = S_IDLE;
               end else begin
                  voice_in = voice_ff + 1'b1;
                  state_in = S_SCAN;
               end
            end
         end
         S_SILENT: begin
            if (status.out_free) begin
               cmd.emit_silent = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         voice_ff <= '0;
         mask_ff  <= '0;
         func_ff  <= FUNC_TICK;
      end else begin
         state_ff <= state_in;
         voice_ff <= voice_in;
         mask_ff  <= mask_in;
         func_ff  <= func_in;
      end
   end

endmodule

FILE: rtl/core/nts_datapath.sv
// Sequencer datapath: note table RAM, voice positions, frame counters,
// tick counter, length registers and the result register.
// Depends on nts_pkg and nts_ram; controlled by nts_ctrl.

module nts_datapath #(
   parameter int NOTES_PER_VOICE = 128,
   parameter int VOICE_COUNT     = 3
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [1:0]              req_func,
   input  logic [1:0]              req_voice,
   input  logic [6:0]              req_index,
   input  logic [15:0]             req_note_freq,
   input  logic [7:0]              req_note_len,
   input  logic                    csr_write_en,
   input  logic [1:0]              csr_index,
   input  logic [7:0]              csr_wdata,
   input  nts_pkg::nts_cmd_type    cmd,
   output nts_pkg::nts_status_type status,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_voice_res,
   output logic [1:0]              rsp_kind,
   output logic [15:0]             rsp_freq,
   output logic [7:0]              rsp_tick_count,
   output logic                    rsp_last
);
   import nts_pkg::*;

   localparam int POS_W     = $clog2(NOTES_PER_VOICE);
   localparam int VW        = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int RAM_DEPTH = VOICE_COUNT << POS_W;
   localparam int AW        = $clog2(RAM_DEPTH);

   logic [POS_W-1:0] pos_ff    [VOICE_COUNT];
   logic [POS_W-1:0] pos_in    [VOICE_COUNT];
   logic [DUR_W-1:0] frames_ff [VOICE_COUNT];
   logic [DUR_W-1:0] frames_in [VOICE_COUNT];
   logic [7:0]       len_ff    [NREGS];
   logic [7:0]       len_in    [NREGS];
   logic [7:0]       tick_ff, tick_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_voice_ff, rsp_kind_ff;
   logic [FREQ_W-1:0] rsp_freq_ff;
   logic [7:0]       rsp_tick_ff;
   logic             rsp_last_ff;

   logic [VW-1:0]      vsel;
   logic [7:0]         len_raw;
   logic [31:0]        len_eff;
   logic [31:0]        pos_inc;
   logic [POS_W-1:0]   new_pos;
   logic [31:0]        ld_voice_ext, ld_index_ext;
   logic               ld_ok;
   logic               ram_we;
   logic [AW-1:0]      ram_addr;
   logic [ENTRY_W-1:0] ram_rdata;
   logic [FREQ_W-1:0]  rd_freq;
   logic               out_free;

   assign vsel         = cmd.voice[VW-1:0];
   assign ld_voice_ext = 32'(req_voice);
   assign ld_index_ext = 32'(req_index);
   assign ld_ok        = (ld_voice_ext < VOICE_COUNT) && (ld_index_ext < NOTES_PER_VOICE);
   assign ram_we       = cmd.accept && (func_type'(req_func) == FUNC_LOAD) && ld_ok;
   assign rd_freq      = ram_rdata[ENTRY_W-1:DUR_W];
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   // table length of the selected voice, clamped to 1..NOTES_PER_VOICE
   always_comb begin
      len_raw = 8'd1;
      for (int i = 0; i < NREGS; i++) begin
         if (32'(cmd.voice) == i) begin
            len_raw = len_ff[i];
         end
      end
      len_eff = 32'(len_raw);
      if (len_eff == 32'd0) begin
         len_eff = 32'd1;
      end else if (len_eff > NOTES_PER_VOICE) begin
         len_eff = NOTES_PER_VOICE;
      end
      pos_inc = 32'(pos_ff[vsel]) + 32'd1;
      if (cmd.func == FUNC_PLAY || pos_inc >= len_eff) begin
         new_pos = '0;
      end else begin
         new_pos = pos_inc[POS_W-1:0];
      end
   end

   always_comb begin
      if (ram_we) begin
         ram_addr = AW'({ld_voice_ext[VW-1:0], ld_index_ext[POS_W-1:0]});
      end else begin
         ram_addr = AW'({vsel, new_pos});
      end
   end

   nts_ram #(
      .DATA_W (ENTRY_W),
      .DEPTH  (RAM_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .re    (cmd.rd_issue),
      .addr  (ram_addr),
      .wdata ({req_note_freq, req_note_len}),
      .rdata (ram_rdata)
   );

   always_comb begin
      status.out_free  = out_free;
      status.trig_mask = '0;
      for (int v = 0; v < VOICE_COUNT; v++) begin
         status.trig_mask[v] = (frames_ff[v] <= 8'd1);
      end
   end

   always_comb begin
      pos_in    = pos_ff;
      frames_in = frames_ff;
      len_in    = len_ff;
      tick_in   = tick_ff;
      if (cmd.accept && func_type'(req_func) == FUNC_TICK) begin
         tick_in = tick_ff + 8'd1;
         for (int v = 0; v < VOICE_COUNT; v++) begin
            if (frames_ff[v] != '0) begin
               frames_in[v] = frames_ff[v] - 1'b1;
            end
         end
      end
      if (cmd.accept && func_type'(req_func) == FUNC_STOP) begin
         for (int v = 0; v < VOICE_COUNT; v++) begin
            pos_in[v]    = '0;
            frames_in[v] = '0;
         end
      end
      if (cmd.rd_issue) begin
         pos_in[vsel] = new_pos;
      end
      if (cmd.emit_note) begin
         frames_in[vsel] = ram_rdata[DUR_W-1:0];
      end
      if (csr_write_en) begin
         case (csr_index)
            REG_LENGTH_VOICE0: len_in[0] = csr_wdata;
            REG_LENGTH_VOICE1: len_in[1] = csr_wdata;
            REG_LENGTH_VOICE2: len_in[2] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.emit_note || cmd.emit_silent) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < VOICE_COUNT; v++) begin
            pos_ff[v]    <= '0;
            frames_ff[v] <= '0;
         end
         for (int i = 0; i < NREGS; i++) begin
            len_ff[i] <= 8'd1;
         end
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         frames_ff    <= frames_in;
         len_ff       <= len_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_note) begin
         rsp_voice_ff <= cmd.voice[1:0];
         rsp_kind_ff  <= (rd_freq == '0) ? KIND_REST : KIND_NOTE;
         rsp_freq_ff  <= rd_freq;
         rsp_tick_ff  <= tick_ff;
         rsp_last_ff  <= cmd.last;
      end else if (cmd.emit_silent) begin
         rsp_voice_ff <= 2'd0;
         rsp_kind_ff  <= KIND_SILENT;
         rsp_freq_ff  <= '0;
         rsp_tick_ff  <= tick_ff;
         rsp_last_ff  <= 1'b1;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_voice_res  = rsp_voice_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_freq       = rsp_freq_ff;
   assign rsp_tick_count = rsp_tick_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

FILE: rtl/core/nts_checker.sv
// Port-level assertions for note_table_sequencer_core, bound to the top level.
// Depends on nts_pkg.

module nts_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_voice_res,
   input logic [1:0]  rsp_kind,
   input logic [15:0] rsp_freq,
   input logic [7:0]  rsp_tick_count,
   input logic        rsp_last
);
   import nts_pkg::*;

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !req_stall && !rsp_valid)
      else $error("not idle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_freq) && $stable(rsp_kind)
         && $stable(rsp_voice_res) && $stable(rsp_last) && $stable(rsp_tick_count))
      else $error("stalled result changed");

   a_kind_freq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == KIND_REST && rsp_freq == 16'd0)
         || (rsp_kind == KIND_NOTE && rsp_freq != 16'd0)
         || (rsp_kind == KIND_SILENT && rsp_freq == 16'd0 && rsp_last
             && rsp_voice_res == 2'd0))
      else $error("result kind does not match payload");

   a_busy_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("new transaction taken before last result");

endmodule

bind note_table_sequencer_core nts_checker u_nts_checker (.*);
